### rtl/core/mfl_pkg.sv
// shared constants and command/status types for the max flow labeling unit
package mfl_pkg;

  localparam int MAX_NODES  = 16;
  localparam int IDX_BITS   = 4;
  localparam int CNT_BITS   = 5;
  localparam int ADDR_BITS  = 2 * IDX_BITS;
  localparam int MEM_DEPTH  = MAX_NODES * MAX_NODES;
  localparam int CAP_BITS   = 16;
  localparam int LABEL_BITS = CAP_BITS + 1;
  localparam int FLOW_BITS  = 20;
  localparam int NC_BITS    = 5;

  localparam logic [1:0] RD_OUT = 2'd0;
  localparam logic [1:0] RD_FWD = 2'd1;
  localparam logic [1:0] RD_BWD = 2'd2;
  localparam logic [1:0] RD_AUG = 2'd3;

  typedef struct packed {
    logic       clr_write;
    logic       load_write;
    logic       cnt_reset;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       acc_clear;
    logic       save_init;
    logic       lab_init;
    logic       pick_u;
    logic       aug_start;
    logic       aug_write;
    logic       out_load;
  } mfl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic cnt_done;
    logic has_cand;
    logic sink_lab;
    logic aug_done;
    logic out_pending;
  } mfl_status_t;

endpackage

### rtl/core/max_flow_labeling_unit.sv
// top level of the max flow labeling unit
// Usage:
//   s_axis carries items: tuser is the mode (0 load one capacity entry, 1 run),
//   tdata holds row, col and capacity. m_axis returns the total flow of a run.
//   cfg_we_i/cfg_wdata_i set the vertex count (2..16, sink is the last vertex);
//   it must be written only while the unit is idle; the unit does not enforce it.
// Timing:
//   after reset both 256-entry stores are zeroed, one entry a cycle, and
//   s_axis_tready stays low meanwhile; node count returns to 16.
//   a load item yields no result; loads stream at one a cycle.
//   a run reads the source row twice, before and after the searches; each
//   labeling search reads the row and column of every vertex that it scans,
//   and each augmenting path reads and writes one residual per edge; the
//   single residual memory read port serialises these reads.
//   the result sits in an output register until m_axis_tready is high;
//   no new item is taken while it waits.
module max_flow_labeling_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // row[3:0], col[7:4], capacity[23:8]
  input  logic [0:0]  s_axis_tuser,   // mode[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // max_flow[19:0], zero[23:20]
);
  import mfl_pkg::*;

  mfl_cmd_t             cmd;
  mfl_status_t          status;
  logic [FLOW_BITS-1:0] max_flow;

  mfl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_mode_i  (s_axis_tuser[0]),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mfl_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .row_i       (s_axis_tdata[3:0]),
    .col_i       (s_axis_tdata[7:4]),
    .cap_i       (s_axis_tdata[23:8]),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .max_flow_o  (max_flow)
  );

  assign m_axis_tdata = {4'b0000, max_flow};

`ifndef ASSERT_OFF
  a_no_accept_while_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("input accepted while a result waits");

  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser[0]) |=> !s_axis_tready)
    else $error("run item did not make the unit busy");

  a_load_stays_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && !s_axis_tuser[0]) |=> s_axis_tready)
    else $error("load item stalled the input");
`endif

endmodule

### rtl/core/mfl_ram.sv
// generic single write port ram with registered read
module mfl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### rtl/core/mfl_datapath.sv
// datapath: capacity and residual stores, labels, augmentation and flow sums
module mfl_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mfl_pkg::mfl_cmd_t                   cmd_i,
  output mfl_pkg::mfl_status_t                status_o,
  input  logic                                cfg_we_i,
  input  logic [mfl_pkg::NC_BITS-1:0]         cfg_wdata_i,
  input  logic [mfl_pkg::IDX_BITS-1:0]        row_i,
  input  logic [mfl_pkg::IDX_BITS-1:0]        col_i,
  input  logic [mfl_pkg::CAP_BITS-1:0]        cap_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [mfl_pkg::FLOW_BITS-1:0]       max_flow_o
);
  import mfl_pkg::*;

  logic [NC_BITS-1:0]    node_count_q;
  logic [CNT_BITS-1:0]   n;
  logic [CNT_BITS-1:0]   n_m1;
  logic [IDX_BITS-1:0]   sink;
  logic [ADDR_BITS:0]    clr_cnt_q;
  logic [CNT_BITS-1:0]   cnt_q;
  logic                  rd_vld_q;
  logic [1:0]            rd_kind_q;
  logic [IDX_BITS-1:0]   rd_v_q;

  logic [MAX_NODES-1:0]  lab_q, scan_q, back_q;
  logic [IDX_BITS-1:0]   pred_q [MAX_NODES];
  logic [LABEL_BITS-1:0] amt_q  [MAX_NODES];
  logic [IDX_BITS-1:0]   u_q, x_q;
  logic [LABEL_BITS-1:0] mag_q, aug_amt_q;
  logic [CNT_BITS-1:0]   guard_q;

  logic [FLOW_BITS-1:0]  acc_q, acc_d, init_q, out_q;
  logic                  out_vld_q;

  logic [MAX_NODES-1:0]  cand_vec;
  logic [IDX_BITS-1:0]   cand;
  logic [IDX_BITS-1:0]   amt_idx;
  logic [IDX_BITS-1:0]   y;
  logic                  bk;
  logic [ADDR_BITS-1:0]  aug_addr;

  logic                  res_we, cap_we;
  logic [ADDR_BITS-1:0]  waddr, raddr;
  logic [CAP_BITS-1:0]   res_wdata, cap_wdata;
  logic [CAP_BITS-1:0]   res_rd, cap_rd;

  logic [LABEL_BITS-1:0] r_ext, f_ext, fwd_amt, bwd_amt;
  logic [CAP_BITS:0]     sum_sat;
  logic [CAP_BITS-1:0]   aug_wdata;

  // clamp node count into the supported range
  always_comb begin
    n = node_count_q;
    if (node_count_q < NC_BITS'(2)) n = CNT_BITS'(2);
    if (node_count_q > NC_BITS'(MAX_NODES)) n = CNT_BITS'(MAX_NODES);
    n_m1 = n - CNT_BITS'(1);
    sink = n_m1[IDX_BITS-1:0];
  end

  // lowest labeled but unscanned vertex
  always_comb begin
    for (int v = 0; v < MAX_NODES; v++) begin
      cand_vec[v] = lab_q[v] && !scan_q[v] && (CNT_BITS'(v) < n);
    end
    cand = '0;
    for (int v = MAX_NODES - 1; v >= 0; v--) begin
      if (cand_vec[v]) cand = IDX_BITS'(v);
    end
  end

  assign amt_idx  = cmd_i.aug_start ? sink : cand;
  assign y        = pred_q[x_q];
  assign bk       = back_q[x_q];
  assign aug_addr = bk ? {x_q, y} : {y, x_q};

  // augmentation update of one residual
  always_comb begin
    sum_sat = {1'b0, res_rd} + aug_amt_q;
    if (bk) begin
      aug_wdata = sum_sat[CAP_BITS] ? {CAP_BITS{1'b1}} : sum_sat[CAP_BITS-1:0];
    end else begin
      aug_wdata = ({1'b0, res_rd} >= aug_amt_q) ?
                  CAP_BITS'({1'b0, res_rd} - aug_amt_q) : '0;
    end
  end

  // memory port muxing
  always_comb begin
    res_we    = cmd_i.clr_write | cmd_i.load_write | cmd_i.aug_write;
    cap_we    = cmd_i.clr_write | cmd_i.load_write;
    waddr     = clr_cnt_q[ADDR_BITS-1:0];
    res_wdata = '0;
    cap_wdata = '0;
    if (cmd_i.load_write) begin
      waddr     = {row_i, col_i};
      res_wdata = cap_i;
      cap_wdata = cap_i;
    end else if (cmd_i.aug_write) begin
      waddr     = aug_addr;
      res_wdata = aug_wdata;
    end
    case (cmd_i.rd_sel)
      RD_OUT:  raddr = {{IDX_BITS{1'b0}}, cnt_q[IDX_BITS-1:0]};
      RD_FWD:  raddr = {u_q, cnt_q[IDX_BITS-1:0]};
      RD_BWD:  raddr = {cnt_q[IDX_BITS-1:0], u_q};
      RD_AUG:  raddr = aug_addr;
      default: raddr = aug_addr;
    endcase
  end

  mfl_ram #(.WIDTH(CAP_BITS), .DEPTH(MEM_DEPTH)) u_res_ram (
    .clk_i   (clk_i),
    .we_i    (res_we),
    .waddr_i (waddr),
    .wdata_i (res_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (res_rd)
  );

  mfl_ram #(.WIDTH(CAP_BITS), .DEPTH(MEM_DEPTH)) u_cap_ram (
    .clk_i   (clk_i),
    .we_i    (cap_we),
    .waddr_i (waddr),
    .wdata_i (cap_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (cap_rd)
  );

  // candidate label amounts for the item returning from memory
  always_comb begin
    r_ext   = {1'b0, res_rd};
    f_ext   = (cap_rd > res_rd) ? {1'b0, cap_rd - res_rd} : '0;
    fwd_amt = (mag_q < r_ext) ? mag_q : r_ext;
    bwd_amt = (mag_q < f_ext) ? mag_q : f_ext;
  end

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.acc_clear) begin
      acc_d = '0;
    end else if (rd_vld_q && rd_kind_q == RD_OUT) begin
      acc_d = acc_q + FLOW_BITS'(res_rd);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NC_BITS'(MAX_NODES);
      clr_cnt_q    <= '0;
      cnt_q        <= '0;
      rd_vld_q     <= 1'b0;
      out_vld_q    <= 1'b0;
      lab_q        <= '0;
      scan_q       <= '0;
    end else begin
      if (cfg_we_i) node_count_q <= cfg_wdata_i;
      if (cmd_i.clr_write) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (cmd_i.cnt_reset) begin
        cnt_q <= '0;
      end else if (cmd_i.rd_en) begin
        cnt_q <= cnt_q + 1'b1;
      end
      rd_vld_q <= cmd_i.rd_en;
      if (cmd_i.out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      if (cmd_i.lab_init) begin
        // only the source starts labeled
        lab_q    <= MAX_NODES'(1);
        scan_q   <= '0;
      end else if (cmd_i.pick_u) begin
        scan_q[cand] <= 1'b1;
      end else if (rd_vld_q && !lab_q[rd_v_q]) begin
        if ((rd_kind_q == RD_FWD && res_rd != '0) ||
            (rd_kind_q == RD_BWD && f_ext != '0)) begin
          lab_q[rd_v_q] <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rd_kind_q <= cmd_i.rd_sel;
    rd_v_q    <= cnt_q[IDX_BITS-1:0];
    acc_q     <= acc_d;
    if (cmd_i.save_init) init_q <= acc_d;
    if (cmd_i.out_load) out_q <= (init_q >= acc_d) ? init_q - acc_d : '0;
    if (cmd_i.lab_init) begin
      back_q    <= '0;
      amt_q[0]  <= {1'b1, {CAP_BITS{1'b0}}};
      pred_q[0] <= '0;
    end else if (rd_vld_q && !lab_q[rd_v_q]) begin
      if (rd_kind_q == RD_FWD && res_rd != '0) begin
        amt_q[rd_v_q]  <= fwd_amt;
        pred_q[rd_v_q] <= u_q;
        back_q[rd_v_q] <= 1'b0;
      end else if (rd_kind_q == RD_BWD && f_ext != '0) begin
        amt_q[rd_v_q]  <= bwd_amt;
        pred_q[rd_v_q] <= u_q;
        back_q[rd_v_q] <= 1'b1;
      end
    end
    if (cmd_i.pick_u) begin
      u_q   <= cand;
      mag_q <= amt_q[amt_idx];
    end
    if (cmd_i.aug_start) begin
      x_q       <= sink;
      guard_q   <= '0;
      aug_amt_q <= amt_q[amt_idx];
    end else if (cmd_i.aug_write) begin
      x_q     <= y;
      guard_q <= guard_q + 1'b1;
    end
  end

  assign status_o.clr_done    = clr_cnt_q[ADDR_BITS];
  assign status_o.cnt_done    = (cnt_q == n);
  assign status_o.has_cand    = |cand_vec;
  assign status_o.sink_lab    = lab_q[sink];
  assign status_o.aug_done    = (x_q == '0) || (guard_q == CNT_BITS'(MAX_NODES));
  assign status_o.out_pending = out_vld_q;

  assign out_valid_o = out_vld_q;
  assign max_flow_o  = out_q;

endmodule

### rtl/core/mfl_ctrl.sv
// controller: sequences clearing, loads, labeling searches and augmentation
module mfl_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_mode_i,
  output logic                 in_ready_o,
  input  mfl_pkg::mfl_status_t status_i,
  output mfl_pkg::mfl_cmd_t    cmd_o
);
  import mfl_pkg::*;

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_SUM0   = 4'd2;
  localparam logic [3:0] ST_INIT   = 4'd3;
  localparam logic [3:0] ST_PICK   = 4'd4;
  localparam logic [3:0] ST_FWD    = 4'd5;
  localparam logic [3:0] ST_BWD    = 4'd6;
  localparam logic [3:0] ST_CHECK  = 4'd7;
  localparam logic [3:0] ST_AUG_RD = 4'd8;
  localparam logic [3:0] ST_AUG_WR = 4'd9;
  localparam logic [3:0] ST_SUM1   = 4'd10;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE) && !status_i.out_pending;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rd_sel = RD_OUT;
    case (state_q)
      ST_CLEAR: begin
        if (status_i.clr_done) state_d = ST_IDLE;
        else cmd_o.clr_write = 1'b1;
      end
      ST_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          if (in_mode_i) begin
            cmd_o.acc_clear = 1'b1;
            cmd_o.cnt_reset = 1'b1;
            state_d = ST_SUM0;
          end else begin
            cmd_o.load_write = 1'b1;
          end
        end
      end
      ST_SUM0: begin
        if (!status_i.cnt_done) begin
          cmd_o.rd_en = 1'b1;
        end else begin
          cmd_o.save_init = 1'b1;
          state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd_o.lab_init = 1'b1;
        state_d = ST_PICK;
      end
      ST_PICK: begin
        cmd_o.cnt_reset = 1'b1;
        if (status_i.has_cand) begin
          cmd_o.pick_u = 1'b1;
          state_d = ST_FWD;
        end else begin
          cmd_o.acc_clear = 1'b1;
          state_d = ST_SUM1;
        end
      end
      ST_FWD: begin
        cmd_o.rd_sel = RD_FWD;
        if (!status_i.cnt_done) begin
          cmd_o.rd_en = 1'b1;
        end else begin
          cmd_o.cnt_reset = 1'b1;
          state_d = ST_BWD;
        end
      end
      ST_BWD: begin
        cmd_o.rd_sel = RD_BWD;
        if (!status_i.cnt_done) cmd_o.rd_en = 1'b1;
        else state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (status_i.sink_lab) begin
          cmd_o.aug_start = 1'b1;
          state_d = ST_AUG_RD;
        end else begin
          state_d = ST_PICK;
        end
      end
      ST_AUG_RD: begin
        cmd_o.rd_sel = RD_AUG;
        if (status_i.aug_done) begin
          state_d = ST_INIT;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d = ST_AUG_WR;
        end
      end
      ST_AUG_WR: begin
        cmd_o.rd_sel    = RD_AUG;
        cmd_o.aug_write = 1'b1;
        state_d = ST_AUG_RD;
      end
      ST_SUM1: begin
        if (!status_i.cnt_done) begin
          cmd_o.rd_en = 1'b1;
        end else begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
